>>> sv/asrp_pkg.sv
// shared types, constants and register indexes of the audio sample ring player
package asrp_pkg;

   // ring store geometry
   localparam int STORE_DEPTH = 4096;
   localparam int PTR_WIDTH   = $clog2(STORE_DEPTH);
   localparam int OCC_WIDTH   = $clog2(STORE_DEPTH + 1);

   // field widths
   localparam int SAMPLE_WIDTH = 16;
   localparam int FILL_WIDTH   = 13;
   localparam int COUNT_WIDTH  = 32;

   // sample arithmetic
   localparam logic signed [16:0] SAMPLE_OFFSET = 17'sd32767;
   localparam logic [15:0]        MID_SCALE     = 16'd32767;

   // operation codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_WORD  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // configuration port
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [1:0] CSR_HALVE_RATE    = 2'd0;
   localparam logic [1:0] CSR_STEREO_SOURCE = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_COUNT  = 2'd2;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [15:0]       source_word;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0]  dac_value;
      logic                     dac_valid;
      logic                     word_dropped;
      logic                     underrun;
      logic                     stream_done;
      logic [FILL_WIDTH-1:0]    fill_level;
   } rsp_type;

   typedef struct packed {
      logic                     halve_rate;
      logic                     stereo_source;
      logic [COUNT_WIDTH-1:0]   sample_count;
   } cfg_type;

endpackage

>>> sv/asrp_ram.sv
// generic single-write, single-read ram with registered read data
module asrp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/asrp_csr.sv
// configuration registers behind the apb-style port
module asrp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [asrp_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [asrp_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [asrp_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output asrp_pkg::cfg_type                     cfg
);
   import asrp_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_fire;

   assign reg_index  = csr_paddr[3:2];
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (reg_index)
            CSR_HALVE_RATE:    cfg_in.halve_rate    = csr_pwdata[0];
            CSR_STEREO_SOURCE: cfg_in.stereo_source = csr_pwdata[0];
            CSR_SAMPLE_COUNT:  cfg_in.sample_count  = csr_pwdata[COUNT_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         CSR_HALVE_RATE:    csr_prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, cfg_ff.halve_rate};
         CSR_STEREO_SOURCE: csr_prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, cfg_ff.stereo_source};
         CSR_SAMPLE_COUNT:  csr_prdata = cfg_ff.sample_count;
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/audio_sample_ring_player_unit.sv
// top level of the audio sample ring player: control, ring store and result stages
//
//   port group   direction  handshake                 payload
//   req_*        in         req_valid / req_ready     req_payload (op, source_word)
//   rsp_*        out        rsp_valid / rsp_ready     rsp_payload (dac value and status)
//   csr_*        in         apb setup + access        halve_rate, stereo_source, sample_count
//
// one transaction is taken per cycle while the read stage can advance; its result is
// registered in the read stage, where the sample ram is read, and then in the output register.
// pointers, occupancy and counters live in flip-flops and update at acceptance, so
// back-to-back ticks and words need no interlock.
// reset clears all control state at once; the sample ram needs no clearing pass.
// a stalled output holds the read stage, and acceptance stops only when both are full.
module audio_sample_ring_player_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  asrp_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output asrp_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [asrp_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [asrp_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [asrp_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import asrp_pkg::*;

   cfg_type cfg;

   // control state
   logic [PTR_WIDTH-1:0]    wptr_ff, wptr_in;
   logic [PTR_WIDTH-1:0]    rptr_ff, rptr_in;
   logic [OCC_WIDTH-1:0]    occ_ff, occ_in;
   logic [COUNT_WIDTH-1:0]  left_ff, left_in;
   logic [1:0]              phase_ff, phase_in;
   logic signed [16:0]      pair_ff, pair_in;

   // read stage
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_use_ram_ff, s1_use_ram_in;
   rsp_type                 s1_ff, s1_in;

   // output register
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_ff, out_in;

   // datapath
   logic                    req_fire;
   logic                    s1_adv;
   logic [1:0]              group_size;
   logic [1:0]              phase_eff;
   logic signed [16:0]      word_off;
   logic signed [17:0]      pair_sum;
   logic signed [17:0]      pair_avg;
   logic                    store_full;
   logic                    push;
   logic [SAMPLE_WIDTH-1:0] push_data;
   logic                    pop;
   logic [SAMPLE_WIDTH-1:0] ram_rdata;

   asrp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake
   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   // sample arithmetic
   assign group_size = 2'd1 + {1'b0, cfg.halve_rate} + {1'b0, cfg.stereo_source};
   assign phase_eff  = (phase_ff >= group_size) ? 2'd0 : phase_ff;
   assign word_off   = {req_payload.source_word[15], req_payload.source_word}
                       + SAMPLE_OFFSET;
   assign pair_sum   = {pair_ff[16], pair_ff} + {word_off[16], word_off};
   // divide by two rounding toward zero
   assign pair_avg   = (pair_sum + {17'd0, pair_sum[17]}) >>> 1;
   assign store_full = (occ_ff == OCC_WIDTH'(STORE_DEPTH));

   // transaction decode and state update
   always_comb begin
      wptr_in       = wptr_ff;
      rptr_in       = rptr_ff;
      occ_in        = occ_ff;
      left_in       = left_ff;
      phase_in      = phase_ff;
      pair_in       = pair_ff;
      push          = 1'b0;
      push_data     = word_off[SAMPLE_WIDTH-1:0];
      pop           = 1'b0;
      s1_in         = '0;
      s1_use_ram_in = 1'b0;
      if (req_fire) begin
         case (req_payload.op)
            OP_START: begin
               wptr_in  = '0;
               rptr_in  = '0;
               occ_in   = '0;
               phase_in = '0;
               pair_in  = '0;
               left_in  = cfg.sample_count;
            end
            OP_WORD: begin
               if (phase_eff == 2'd0) begin
                  if (cfg.halve_rate) begin
                     pair_in = word_off;
                  end else begin
                     push = 1'b1;
                  end
               end else if (phase_eff == 2'd1 && cfg.halve_rate) begin
                  push      = 1'b1;
                  push_data = pair_avg[SAMPLE_WIDTH-1:0];
               end
               phase_in = (phase_eff + 2'd1 >= group_size) ? 2'd0 : phase_eff + 2'd1;
               if (push) begin
                  if (store_full) begin
                     s1_in.word_dropped = 1'b1;
                  end else begin
                     wptr_in = (wptr_ff == PTR_WIDTH'(STORE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
                     occ_in  = occ_ff + 1'b1;
                  end
               end
            end
            OP_TICK: begin
               if (left_ff != '0) begin
                  if (occ_ff != '0) begin
                     pop             = 1'b1;
                     s1_use_ram_in   = 1'b1;
                     s1_in.dac_valid = 1'b1;
                     rptr_in = (rptr_ff == PTR_WIDTH'(STORE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
                     occ_in  = occ_ff - 1'b1;
                     left_in = left_ff - 1'b1;
                  end else begin
                     s1_in.underrun  = 1'b1;
                     s1_in.dac_value = MID_SCALE;
                  end
               end
            end
            default: begin
               // unused code: status only
            end
         endcase
         s1_in.stream_done = (left_in == '0);
         s1_in.fill_level  = FILL_WIDTH'(occ_in);
      end
   end

   // sample store
   asrp_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (push && !store_full),
      .wr_addr (wptr_ff),
      .wr_data (push_data),
      .rd_en   (pop),
      .rd_addr (rptr_ff),
      .rd_data (ram_rdata)
   );

   // stage movement
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_adv) begin
         out_valid_in = 1'b1;
         out_in       = s1_ff;
         if (s1_use_ram_ff) begin
            out_in.dac_value = ram_rdata;
         end
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         occ_ff       <= '0;
         left_ff      <= '0;
         phase_ff     <= '0;
         pair_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         occ_ff       <= occ_in;
         left_ff      <= left_in;
         phase_ff     <= phase_in;
         pair_ff      <= pair_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff         <= s1_in;
         s1_use_ram_ff <= s1_use_ram_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

>>> test/tb_top.sv
// self-checking testbench of the audio sample ring player: predictor, driver, monitor, csr writes
`timescale 1ns / 100ps

module tb_top;
   import asrp_pkg::*;

   // the op code that the block ignores
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int REPORT_LIMIT = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   rsp_type                   rsp_payload;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   audio_sample_ring_player_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // queues between stimulus, driver and monitor
   req_type player_items_todo [$];
   rsp_type dac_results_due [$];

   // predictor copy of configuration and state
   logic                    halve_cfg  = 1'b0;
   logic                    stereo_cfg = 1'b0;
   logic [COUNT_WIDTH-1:0]  count_cfg  = '0;
   logic [SAMPLE_WIDTH-1:0] ring_copy [STORE_DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr     = '0;
   logic [PTR_WIDTH-1:0]    rd_ptr     = '0;
   logic [OCC_WIDTH-1:0]    held_count = '0;
   logic [COUNT_WIDTH-1:0]  left_count = '0;
   logic [1:0]              group_pos  = '0;
   logic signed [16:0]      pair_first = '0;

   // run bookkeeping
   int idle_pct = 13;
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int played_seen = 0;
   int drops_seen = 0;
   int underruns_seen = 0;
   int stall_cycles = 0;

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // write one sample into the ring copy, returns 1 when the ring is full
   function automatic logic ring_push(input logic [SAMPLE_WIDTH-1:0] value);
      if (held_count >= STORE_DEPTH)
         return 1'b1;
      ring_copy[wr_ptr] = value;
      wr_ptr = wr_ptr + 1'b1;
      held_count = held_count + 1'b1;
      return 1'b0;
   endfunction

   // expected result of one transaction, advancing the predictor state
   function automatic rsp_type next_dac_result(input req_type item);
      rsp_type            r;
      logic [1:0]         group_len;
      logic signed [16:0] offset_word;
      logic signed [17:0] pair_sum;
      logic signed [17:0] pair_avg;
      r = '0;
      group_len = 2'd1 + {1'b0, halve_cfg} + {1'b0, stereo_cfg};
      case (item.op)
         OP_START: begin
            wr_ptr = '0;
            rd_ptr = '0;
            held_count = '0;
            group_pos = '0;
            pair_first = '0;
            left_count = count_cfg;
         end
         OP_WORD: begin
            offset_word = $signed(item.source_word) + SAMPLE_OFFSET;
            // a register change can leave the phase past the group
            if (group_pos >= group_len)
               group_pos = '0;
            if (group_pos == 2'd0) begin
               if (halve_cfg)
                  pair_first = offset_word;
               else
                  r.word_dropped = ring_push(offset_word[15:0]);
            end else if (group_pos == 2'd1 && halve_cfg) begin
               pair_sum = pair_first + offset_word;
               pair_avg = pair_sum / 18'sd2;
               r.word_dropped = ring_push(pair_avg[15:0]);
            end
            group_pos = (group_pos + 2'd1 >= group_len) ? 2'd0 : group_pos + 2'd1;
         end
         OP_TICK: begin
            if (left_count != 0) begin
               if (held_count != 0) begin
                  r.dac_value = ring_copy[rd_ptr];
                  r.dac_valid = 1'b1;
                  rd_ptr = rd_ptr + 1'b1;
                  held_count = held_count - 1'b1;
                  left_count = left_count - 1'b1;
               end else begin
                  r.underrun = 1'b1;
                  r.dac_value = MID_SCALE;
               end
            end
         end
         default: ;
      endcase
      r.stream_done = (left_count == 0);
      r.fill_level = held_count;
      return r;
   endfunction

   // compare one field and report the first few mismatches
   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s at result %0d: expected %0h, got %0h",
                     label, results_seen, want, got);
      end
   endfunction

   // driver: predict on acceptance, then present the next pending transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            dac_results_due.push_back(next_dac_result(req_payload));
            items_sent++;
         end
         if (!req_valid || req_ready) begin
            if (player_items_todo.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= player_items_todo.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (dac_results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result %0d: %p", results_seen, rsp_payload);
            end else begin
               want = dac_results_due.pop_front();
               check_field("dac_value", 32'(want.dac_value), 32'(rsp_payload.dac_value));
               check_field("dac_valid", 32'(want.dac_valid), 32'(rsp_payload.dac_valid));
               check_field("word_dropped", 32'(want.word_dropped),
                           32'(rsp_payload.word_dropped));
               check_field("underrun", 32'(want.underrun), 32'(rsp_payload.underrun));
               check_field("stream_done", 32'(want.stream_done),
                           32'(rsp_payload.stream_done));
               check_field("fill_level", 32'(want.fill_level), 32'(rsp_payload.fill_level));
            end
            if (rsp_payload.dac_valid) played_seen++;
            if (rsp_payload.word_dropped) drops_seen++;
            if (rsp_payload.underrun) underruns_seen++;
         end
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   // apb write: setup cycle, access cycle, register taken at the access edge
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         CSR_HALVE_RATE:    halve_cfg = value[0];
         CSR_STEREO_SOURCE: stereo_cfg = value[0];
         CSR_SAMPLE_COUNT:  count_cfg = value;
         default: ;
      endcase
   endtask

   task automatic set_player(input logic halve, input logic stereo, input logic [31:0] count);
      csr_write(CSR_HALVE_RATE, {31'd0, halve});
      csr_write(CSR_STEREO_SOURCE, {31'd0, stereo});
      csr_write(CSR_SAMPLE_COUNT, count);
   endtask

   // sender holds off until every queued transaction has been answered
   task automatic drain;
      while (player_items_todo.size() > 0 || req_valid || dac_results_due.size() > 0)
         @(posedge clock);
   endtask

   task automatic queue_item(input logic [1:0] op, input logic [15:0] word);
      req_type item;
      item.op = op;
      item.source_word = word;
      player_items_todo.push_back(item);
   endtask

   function automatic logic [15:0] random_word;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 16'h8000;
      if (roll < 20) return 16'h7FFF;
      if (roll < 25) return 16'h0000;
      if (roll < 30) return 16'hFFFF;
      return 16'($urandom());
   endfunction

   function automatic logic [31:0] random_count;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 32'd0;
      if (roll < 20) return 32'hFFFF_FFFF;
      if (roll < 30) return $urandom();
      return $urandom_range(1, 120);
   endfunction

   task automatic queue_random_item;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 52)
         queue_item(OP_WORD, random_word());
      else if (roll < 92)
         queue_item(OP_TICK, 16'($urandom()));
      else if (roll < 96)
         queue_item(OP_SPARE, 16'($urandom()));
      else
         queue_item(OP_START, 16'($urandom()));
   endtask

   // stimulus
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // plain mode: value extremes, ticks before start, underrun, ignored op, end of stream
      set_player(1'b0, 1'b0, 32'd5);
      queue_item(OP_TICK, 16'h0000);
      queue_item(OP_START, 16'h0000);
      queue_item(OP_TICK, 16'hFFFF);
      queue_item(OP_WORD, 16'h8000);
      queue_item(OP_WORD, 16'h7FFF);
      queue_item(OP_WORD, 16'h0000);
      queue_item(OP_WORD, 16'hFFFF);
      queue_item(OP_WORD, 16'h0001);
      queue_item(OP_SPARE, 16'h5A5A);
      repeat (6) queue_item(OP_TICK, 16'h0000);
      drain();

      // halve mode: averages that truncate toward zero at the bottom of the range
      set_player(1'b1, 1'b0, 32'd4);
      queue_item(OP_START, 16'h0000);
      queue_item(OP_WORD, 16'h8000);
      queue_item(OP_WORD, 16'h8000);
      queue_item(OP_WORD, 16'h8000);
      queue_item(OP_WORD, 16'h8001);
      queue_item(OP_WORD, 16'h7FFF);
      queue_item(OP_WORD, 16'h7FFF);
      queue_item(OP_WORD, 16'h0000);
      queue_item(OP_WORD, 16'h0001);
      repeat (4) queue_item(OP_TICK, 16'h0000);
      drain();

      // halve plus stereo, then a group change that leaves the phase past the group
      set_player(1'b1, 1'b1, 32'hFFFF_FFFF);
      queue_item(OP_START, 16'h0000);
      repeat (5) queue_item(OP_WORD, random_word());
      queue_item(OP_TICK, 16'h0000);
      drain();
      set_player(1'b0, 1'b1, 32'd0);
      repeat (3) queue_item(OP_WORD, random_word());
      repeat (3) queue_item(OP_TICK, 16'h0000);
      queue_item(OP_START, 16'h0000);
      queue_item(OP_TICK, 16'h0000);
      drain();

      // fill the ring past full, then drops in halve mode, then drain some
      set_player(1'b0, 1'b0, 32'd4200);
      queue_item(OP_START, 16'h0000);
      repeat (STORE_DEPTH + 4) queue_item(OP_WORD, 16'($urandom()));
      drain();
      csr_write(CSR_HALVE_RATE, 32'd1);
      repeat (6) queue_item(OP_WORD, random_word());
      repeat (40) queue_item(OP_TICK, 16'h0000);
      repeat (10) queue_item(OP_WORD, random_word());
      drain();

      // random phases, one of them with no idling on either side
      for (int phase_no = 0; phase_no < 9; phase_no++) begin
         idle_pct = (phase_no == 4) ? 0 : 13;
         set_player(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), random_count());
         if ($urandom_range(0, 3) != 0)
            queue_item(OP_START, 16'($urandom()));
         repeat (150) queue_random_item();
         drain();
      end
      idle_pct = 13;

      // allow the pipeline to settle before the verdict
      repeat (10) @(posedge clock);
      $display("sent %0d transactions, checked %0d results", items_sent, results_seen);
      $display("played %0d samples, %0d drops, %0d underruns, %0d mismatches",
               played_seen, drops_seen, underruns_seen, mismatches);
      if (mismatches == 0 && dac_results_due.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
